/* hw/rtl/led_frame_buffer_with_host_override_macros.svh */
// ----------------------------------------------------------------------------
// LED frame buffer assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LED_FRAME_BUFFER_WITH_HOST_OVERRIDE_MACROS_SVH
`define LED_FRAME_BUFFER_WITH_HOST_OVERRIDE_MACROS_SVH
`ifndef SYNTHESIS
`define LFB_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define LFB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define LFB_ASSERT(lbl, pre, post)
`define LFB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* hw/rtl/lfb_pkg.sv */
// ----------------------------------------------------------------------------
// LED frame buffer package
// Sizes, codes and word types shared by the frame buffer modules.
// ----------------------------------------------------------------------------
package lfb_pkg;

  localparam int KEY_COUNT   = 28;
  localparam int LOGO_COUNT  = 6;
  localparam int KEY_WORDS   = 2 * KEY_COUNT;
  localparam int TOTAL_WORDS = KEY_WORDS + LOGO_COUNT;
  localparam int KEY_AW      = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CNT_W       = $clog2(TOTAL_WORDS);

  localparam logic [7:0]  KEY_LIMIT      = 8'(KEY_COUNT);
  localparam logic [63:0] REFRESH_GAP_US = 64'd5000;
  localparam logic [63:0] HOLD_US        = 64'(10 * 1000 * 1000);

  localparam logic [1:0] OP_SET_KEY  = 2'd0;
  localparam logic [1:0] OP_SET_LOGO = 2'd1;
  localparam logic [1:0] OP_REFRESH  = 2'd2;

  localparam logic [1:0] CFG_KEY_BRIGHT  = 2'd0;
  localparam logic [1:0] CFG_LOGO_BRIGHT = 2'd1;

  localparam logic CH_KEY  = 1'b0;
  localparam logic CH_LOGO = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  key_index;
    logic [23:0] color;
    logic        from_host;
    logic [63:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic        channel;
    logic [23:0] pixel;
    logic        last_word;
  } out_word_t;

  typedef struct packed {
    logic held;
    logic gap_ok;
  } lfb_tmr_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_WRITE  = 4'b0100,
    S_STREAM = 4'b1000
  } state_t;

endpackage

/* hw/rtl/led_frame_buffer_with_host_override.sv */
// ----------------------------------------------------------------------------
// LED frame buffer with host override
// Key and logo pixel store with brightness scaling and refresh streaming.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command words (set key, set logo, refresh), valid/stall.
//   out_* : pixel words of a refresh burst, valid/stall, output register.
//   cfg_* : brightness writes, index 0 keys, index 1 logo; write when idle.
// A command word is taken in S_IDLE and checked against the hold-off and
// refresh timers in the next, in S_EXEC; a set command stores its colour in
// S_WRITE, and commands that stream nothing return to S_IDLE from S_EXEC.
// A refresh reads key 0 in S_EXEC and loads its first word into the output
// register in S_STREAM; the 2*KEY_COUNT + LOGO_COUNT words then leave at one
// per cycle unless stalled, one key RAM read per key (each key is sent twice).
// The next command is accepted the cycle after the last burst word is loaded.
// A stalled receiver holds the output word and pauses the burst.
// Reset clears the timers, the logo pixel and per-key valid bits, so
// unwritten keys read as zero with no clearing pass; brightness is 255.
// ----------------------------------------------------------------------------
`include "led_frame_buffer_with_host_override_macros.svh"

module led_frame_buffer_with_host_override import lfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  state_t              state_r, state_nxt;
  in_word_t            item_r;
  logic                drop_r;
  lfb_tmr_t            tmr;
  logic [7:0]          key_lvl_r, logo_lvl_r;
  logic [7:0]          level;
  logic [23:0]         scaled;
  logic [23:0]         logo_r;
  logic [KEY_COUNT-1:0] kvalid_r;
  logic                rd_en;
  logic [KEY_AW-1:0]   rd_addr;
  logic                rd_val_r;
  logic [23:0]         rdata;
  logic                wr_en;
  logic [KEY_AW-1:0]   wr_addr;
  logic [CNT_W-1:0]    cnt_r;
  logic                load;
  logic                key_word;
  out_word_t           word;
  out_word_t           out_r;
  logic                out_vld_r;
  logic                go_refresh;

  assign level = (item_r.opcode == OP_SET_LOGO) ? logo_lvl_r : key_lvl_r;

  lfb_timer u_timer (
    .clk   (clk),
    .rst_n (rst_n),
    .chk   (state_r == S_EXEC),
    .op    (item_r.opcode),
    .host  (item_r.from_host),
    .now   (item_r.now_us),
    .res   (tmr)
  );

  lfb_scale u_scale (
    .clk    (clk),
    .color  (item_r.color),
    .level  (level),
    .scaled (scaled)
  );

  lfb_ram #(.WIDTH(24), .DEPTH(KEY_COUNT)) u_key_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (scaled),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    in_stall   = (state_r != S_IDLE);
    go_refresh = (state_r == S_EXEC) && (item_r.opcode == OP_REFRESH) && tmr.gap_ok;
    load       = (state_r == S_STREAM) && (!out_vld_r || !out_stall);
    key_word   = cnt_r < CNT_W'(KEY_WORDS);
    wr_addr    = item_r.key_index[KEY_AW-1:0];
    wr_en      = (state_r == S_WRITE) && !drop_r && (item_r.opcode == OP_SET_KEY) &&
                 (item_r.key_index < KEY_LIMIT);

    rd_en   = 1'b0;
    rd_addr = '0;
    if (go_refresh) begin
      rd_en = 1'b1;
    end else if (load && cnt_r[0] && (cnt_r < CNT_W'(KEY_WORDS - 1))) begin
      rd_en   = 1'b1;
      rd_addr = KEY_AW'(cnt_r[CNT_W-1:1] + 1'b1);
    end

    word.channel   = key_word ? CH_KEY : CH_LOGO;
    word.pixel     = key_word ? (rd_val_r ? rdata : 24'd0) : logo_r;
    word.last_word = (cnt_r == CNT_W'(TOTAL_WORDS - 1));

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (item_r.opcode == OP_SET_KEY || item_r.opcode == OP_SET_LOGO) begin
          state_nxt = S_WRITE;
        end else if (go_refresh) begin
          state_nxt = S_STREAM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
      end
      S_STREAM: begin
        if (load && word.last_word) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      key_lvl_r  <= 8'hff;
      logo_lvl_r <= 8'hff;
      logo_r     <= '0;
      kvalid_r   <= '0;
      out_vld_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == CFG_KEY_BRIGHT) key_lvl_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_LOGO_BRIGHT) logo_lvl_r <= cfg_wdata;
      if (wr_en) kvalid_r[wr_addr] <= 1'b1;
      if (state_r == S_WRITE && !drop_r && item_r.opcode == OP_SET_LOGO) begin
        logo_r <= scaled;
      end
      if (go_refresh) begin
        cnt_r <= '0;
      end else if (load) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
    if (state_r == S_EXEC) drop_r <= tmr.held;
    if (rd_en) rd_val_r <= kvalid_r[rd_addr];
    if (load) out_r <= word;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `LFB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `LFB_ASSERT(a_last_is_logo, out_valid && out_data.last_word, out_data.channel == CH_LOGO)
  `LFB_ASSERT_NEXT(a_burst_start, go_refresh, state_r == S_STREAM && cnt_r == '0)
  `LFB_ASSERT(a_stream_blocks_input, state_r == S_STREAM, in_stall)

endmodule

/* hw/rtl/lfb_ram.sv */
// ----------------------------------------------------------------------------
// LED frame buffer RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 28,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/lfb_scale.sv */
// ----------------------------------------------------------------------------
// LED frame buffer colour scaler
// Per-byte brightness scaling: byte * level / 255, products registered.
// ----------------------------------------------------------------------------
module lfb_scale import lfb_pkg::*; (
  input  logic        clk,
  input  logic [23:0] color,
  input  logic [7:0]  level,
  output logic [23:0] scaled
);

  logic [15:0] prod_r [3];
  logic [16:0] sum [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= color[i*8 +: 8] * level;
    end
  end

  // exact x / 255 for x < 65280
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = {1'b0, prod_r[i]} + {9'd0, prod_r[i][15:8]} + 17'd1;
      scaled[i*8 +: 8] = sum[i][15:8];
    end
  end

endmodule

/* hw/rtl/lfb_timer.sv */
// ----------------------------------------------------------------------------
// LED frame buffer timer checks
// Host hold-off deadline and refresh spacing against the item timestamp.
// ----------------------------------------------------------------------------
module lfb_timer import lfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        chk,
  input  logic [1:0]  op,
  input  logic        host,
  input  logic [63:0] now,
  output lfb_tmr_t    res
);

  logic [63:0] last_r;
  logic [63:0] dl_r;

  always_comb begin
    res.held   = !host && (now < dl_r);
    res.gap_ok = (now - last_r) >= REFRESH_GAP_US;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      dl_r   <= '0;
    end else if (chk) begin
      if ((op == OP_SET_KEY || op == OP_SET_LOGO) && host) begin
        dl_r <= now + HOLD_US;
      end
      if (op == OP_REFRESH && res.gap_ok) begin
        last_r <= now;
      end
    end
  end

endmodule
